FILE: rtl/rbd_pkg.sv
package rbd_pkg;

	// field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned REP_W    = 30;
	localparam int unsigned RUN_W    = 29;
	localparam int unsigned LIT_W    = 8;
	localparam int unsigned HDR_CNT_W = 2;

	// one compressed byte as it arrives
	typedef struct packed {
		logic [BYTE_W-1:0] code_byte;
		logic              end_of_stream;
	} in_item_t;

	// one decoded byte with its repeat count
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic [REP_W-1:0]  repeat_count;
		logic              stream_done;
		logic              truncated;
	} out_item_t;

endpackage

FILE: rtl/rbd_in_stage.sv
module rbd_in_stage
	import rbd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	input  logic     advance,
	output logic     valid_s1,
	output in_item_t item_s1
);

	// stage is free when empty or when its request moves on this cycle
	assign in_ready = !valid_s1 || advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

endmodule

FILE: rtl/rbd_parser.sv
module rbd_parser
	import rbd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  item_s1,
	input  logic      advance,
	output logic      emit,
	output out_item_t result
);

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_COUNT   = 2'd1;
	localparam logic [1:0] PH_VALUE   = 2'd2;
	localparam logic [1:0] PH_LITERAL = 2'd3;

	logic [1:0]           phase_q, phase_d;
	logic [HDR_CNT_W-1:0] cnt_left_q, cnt_left_d;
	logic [RUN_W-1:0]     run_count_q, run_count_d;
	logic [LIT_W-1:0]     lit_left_q, lit_left_d;

	logic [BYTE_W-1:0] b;
	logic              eos;

	assign b   = item_s1.code_byte;
	assign eos = item_s1.end_of_stream;

	// parse step for the request in stage one
	always_comb begin
		phase_d     = phase_q;
		cnt_left_d  = cnt_left_q;
		run_count_d = run_count_q;
		lit_left_d  = lit_left_q;
		emit        = 1'b0;
		result      = '0;
		case (phase_q)
			PH_IDLE: begin
				if (b[7]) begin
					run_count_d = {{(RUN_W-5){1'b0}}, b[4:0]};
					cnt_left_d  = b[6:5];
					phase_d     = (b[6:5] != '0) ? PH_COUNT : PH_VALUE;
					result.truncated = 1'b1;
				end else begin
					lit_left_d = {1'b0, b[6:0]} + LIT_W'(1);
					phase_d    = PH_LITERAL;
				end
				// final byte on a control byte: end marker only, flagged truncated for a run header
				if (eos) begin
					emit               = 1'b1;
					result.stream_done = 1'b1;
				end
			end
			PH_COUNT: begin
				run_count_d = {run_count_q[RUN_W-BYTE_W-1:0], b};
				cnt_left_d  = cnt_left_q - HDR_CNT_W'(1);
				if (cnt_left_d == '0) begin
					phase_d = PH_VALUE;
				end
				// stream ends inside the run header
				if (eos) begin
					emit               = 1'b1;
					result.stream_done = 1'b1;
					result.truncated   = 1'b1;
				end
			end
			PH_VALUE: begin
				emit                = 1'b1;
				result.data_byte    = b;
				result.repeat_count = {1'b0, run_count_q} + REP_W'(1);
				result.stream_done  = eos;
				phase_d             = PH_IDLE;
			end
			PH_LITERAL: begin
				emit                = 1'b1;
				result.data_byte    = b;
				result.repeat_count = REP_W'(1);
				result.stream_done  = eos;
				lit_left_d          = lit_left_q - LIT_W'(1);
				if (lit_left_d == '0) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		// any final byte or return to idle clears the parse state
		if (eos || phase_d == PH_IDLE) begin
			phase_d     = PH_IDLE;
			cnt_left_d  = '0;
			run_count_d = '0;
			lit_left_d  = '0;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cnt_left_q  <= '0;
			run_count_q <= '0;
			lit_left_q  <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			cnt_left_q  <= cnt_left_d;
			run_count_q <= run_count_d;
			lit_left_q  <= lit_left_d;
		end
	end

endmodule

FILE: rtl/rbd_out_reg.sv
module rbd_out_reg
	import rbd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  out_item_t result,
	output logic      slot_free,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	// slot can take a new result when empty or being drained
	assign slot_free = !out_valid || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (slot_free) begin
			out_valid <= load;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load && slot_free) begin
			out_data <= result;
		end
	end

endmodule

FILE: rtl/rle_byte_decoder.sv
// path: an accepted byte is registered in stage one, parsed there, and its result registered in the output register
// throughput: one compressed byte per cycle while not stalled; control and count bytes give no result unless final
// stalls: only a full result register with out_ready low holds up the input, when the stage one byte gives a result
// reset: arst_n clears the parse state and both valid flags at once
module rle_byte_decoder
	import rbd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      emit;
	out_item_t result;
	logic      slot_free;
	logic      advance;

	// stage one request moves when it has no result or the result slot is free
	assign advance = valid_s1 && (!emit || slot_free);

	rbd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rbd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.advance (advance),
		.emit    (emit),
		.result  (result)
	);

	rbd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit),
		.result    (result),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
